// ===== rtl/dsfr_pkg.sv =====
// Shared types, constants and the flag decode for the deck status frame receiver.
// No dependencies; imported by the front, back and top modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package dsfr_pkg;

  localparam logic [15:0] CmdStatus = 16'h7920;
  localparam logic [15:0] CmdAck    = 16'h1001;
  localparam logic [15:0] CmdNack   = 16'h1112;

  localparam int unsigned PosW      = 5;
  localparam logic [PosW-1:0] FrameLenOffset = 5'd2;
  localparam logic [PosW-1:0] MaxFramePos    = 5'd17;

  localparam logic [PosW-1:0] PosCmdHi  = 5'd0;
  localparam logic [PosW-1:0] PosCmdLo  = 5'd1;
  localparam logic [PosW-1:0] PosData2  = 5'd2;
  localparam logic [PosW-1:0] PosData3  = 5'd3;
  localparam logic [PosW-1:0] PosData4  = 5'd4;
  localparam logic [PosW-1:0] PosData10 = 5'd10;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned FlagsW     = 13;

  typedef enum logic [2:0] {
    EvStatus = 3'd0,
    EvAck    = 3'd1,
    EvNack   = 3'd2,
    EvOther  = 3'd3,
    EvBadSum = 3'd4
  } event_e;

  // one checked frame, as handed from front to back
  typedef struct packed {
    logic        bad_sum;
    logic [15:0] cmd;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  b4;
    logic [7:0]  b10;
    logic [7:0]  sum;
  } frame_t;

  typedef struct packed {
    event_e            event_res;
    logic [15:0]       command_word;
    logic [FlagsW-1:0] deck_flags;
    logic              flags_updated;
    logic [7:0]        nack_reason;
  } result_t;

  function automatic logic [FlagsW-1:0] decode_flags(frame_t f);
    logic [FlagsW-1:0] r;
    r[0]  = f.b3[0];
    r[1]  = f.b3[1];
    r[2]  = f.b3[2];
    r[3]  = f.b3[3];
    r[4]  = f.b3[5];
    r[5]  = f.b2[5];
    r[6]  = f.b2[0];
    r[7]  = f.b3[7];
    r[8]  = f.b4[4];
    r[9]  = f.b4[2];
    r[10] = f.b4[1];
    r[11] = f.b10[5];
    r[12] = f.b10[4];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dsfr_fifo.sv =====
// Small first-word-fall-through register queue.
// Used between front and back and on the result side; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dsfr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("queue count beyond depth");
  a_push_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a request");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && empty_o && !push_i) |=> $stable(count_q))
    else $error("pop on empty queue moved count");
`endif

endmodule

`default_nettype wire

// ===== rtl/dsfr_front.sv =====
// Front part: tracks byte position, length and running sum, checks the checksum
// byte and emits one frame record per frame. Depends on dsfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsfr_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic      datagram_end_i,
  output logic           frame_valid_o,
  output dsfr_pkg::frame_t frame_o
);
  import dsfr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, len_q, len_d, len_cur;
  logic [7:0]      sum_q, sum_d, sum_base;
  logic            discard_q, discard_d;
  logic [7:0]      b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;
  logic [7:0]      b3_q, b3_d, b4_q, b4_d, b10_q, b10_d;
  logic            bad;

  assign len_cur  = (pos_q == '0) ? PosW'({1'b0, rx_byte_i[3:0]}) + FrameLenOffset : len_q;
  assign sum_base = (pos_q == '0) ? 8'd0 : sum_q;
  assign bad      = (sum_q != rx_byte_i);

  assign frame_o.bad_sum = bad;
  assign frame_o.cmd     = {b0_q, b1_q};
  assign frame_o.b2      = b2_q;
  assign frame_o.b3      = b3_q;
  assign frame_o.b4      = b4_q;
  assign frame_o.b10     = b10_q;
  assign frame_o.sum     = sum_q;

  always_comb begin
    pos_d         = pos_q;
    len_d         = len_q;
    sum_d         = sum_q;
    discard_d     = discard_q;
    b0_d          = b0_q;
    b1_d          = b1_q;
    b2_d          = b2_q;
    b3_d          = b3_q;
    b4_d          = b4_q;
    b10_d         = b10_q;
    frame_valid_o = 1'b0;
    if (accept_i) begin
      if (discard_q) begin
        if (datagram_end_i) begin
          discard_d = 1'b0;
        end
      end else if (pos_q != len_cur) begin
        len_d = len_cur;
        sum_d = sum_base + rx_byte_i;
        pos_d = pos_q + 1'b1;
        unique case (pos_q)
          PosCmdHi:  b0_d  = rx_byte_i;
          PosCmdLo:  b1_d  = rx_byte_i;
          PosData2:  b2_d  = rx_byte_i;
          PosData3:  b3_d  = rx_byte_i;
          PosData4:  b4_d  = rx_byte_i;
          PosData10: b10_d = rx_byte_i;
          default: ;
        endcase
      end else begin
        frame_valid_o = 1'b1;
        pos_d         = '0;
        discard_d     = bad && !datagram_end_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      len_q     <= '0;
      sum_q     <= '0;
      discard_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      len_q     <= len_d;
      sum_q     <= sum_d;
      discard_q <= discard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q  <= b0_d;
    b1_q  <= b1_d;
    b2_q  <= b2_d;
    b3_q  <= b3_d;
    b4_q  <= b4_d;
    b10_q <= b10_d;
  end

`ifndef SYNTHESIS
  a_discard_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discard_q |-> pos_q == '0) else $error("dropping mid-frame");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxFramePos) else $error("position beyond longest frame");
  a_frame_at_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o |-> (!discard_q && pos_q == len_q && pos_q != '0))
    else $error("frame emitted off the checksum byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/dsfr_back.sv =====
// Back part: classes each checked frame and keeps the deck flags and the last
// status checksum. Depends on dsfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsfr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             frame_valid_i,
  input  wire dsfr_pkg::frame_t frame_i,
  output logic                  frame_pop_o,
  input  wire logic             res_ready_i,
  output logic                  res_push_o,
  output dsfr_pkg::result_t     res_o
);
  import dsfr_pkg::*;

  logic [FlagsW-1:0] flags_q, flags_d;
  logic [7:0]        prev_sum_q, prev_sum_d;
  logic              upd;

  assign frame_pop_o = frame_valid_i && res_ready_i;
  assign res_push_o  = frame_pop_o;

  always_comb begin
    upd               = 1'b0;
    res_o.event_res   = EvOther;
    res_o.nack_reason = 8'd0;
    if (frame_i.bad_sum) begin
      res_o.event_res = EvBadSum;
    end else if (frame_i.cmd == CmdStatus) begin
      res_o.event_res = EvStatus;
      upd             = (frame_i.sum != prev_sum_q);
    end else if (frame_i.cmd == CmdAck) begin
      res_o.event_res = EvAck;
    end else if (frame_i.cmd == CmdNack) begin
      res_o.event_res   = EvNack;
      res_o.nack_reason = frame_i.b2;
    end
    flags_d    = upd ? decode_flags(frame_i) : flags_q;
    prev_sum_d = upd ? frame_i.sum : prev_sum_q;
    res_o.command_word  = frame_i.cmd;
    res_o.deck_flags    = flags_d;
    res_o.flags_updated = upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      prev_sum_q <= '0;
    end else if (frame_pop_o) begin
      flags_q    <= flags_d;
      prev_sum_q <= prev_sum_d;
    end
  end

`ifndef SYNTHESIS
  a_upd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.flags_updated) |-> res_o.event_res == EvStatus)
    else $error("flag reload on non-status frame");
  a_upd_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.flags_updated) |=> prev_sum_q == $past(frame_i.sum))
    else $error("status checksum not kept");
  a_nack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.event_res != EvNack) |-> res_o.nack_reason == 8'd0)
    else $error("nack reason on non-nack frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/deck_status_frame_receiver_unit.sv =====
// Deck status frame receiver: one received byte per cycle while the frame queue has room.
// A result reaches the result ports once its checksum byte is accepted, through
// registers: front registers to the frame queue, back to the result queue.
// Bytes are taken while the frame queue has room; each queue holds two entries by default (QDepth).
// Reset (asynchronous, active low) clears position, sum, flags and queues at once.
`timescale 1ns / 1ps
`default_nettype none

module deck_status_frame_receiver_unit #(
  parameter int unsigned QDepth = dsfr_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        datagram_end_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       event_res_o,
  output logic [15:0]      command_word_o,
  output logic [12:0]      deck_flags_o,
  output logic             flags_updated_o,
  output logic [7:0]       nack_reason_o
);
  import dsfr_pkg::*;

  localparam int unsigned FrameW  = $bits(frame_t);
  localparam int unsigned ResultW = $bits(result_t);

  frame_t  front_frame, back_frame;
  result_t back_res, out_res;
  logic    front_valid, mid_full, mid_empty, mid_pop, out_full, res_push;
  logic [FrameW-1:0]  mid_data;
  logic [ResultW-1:0] out_data;

  assign full = mid_full;

  dsfr_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i       (push && !mid_full),
    .rx_byte_i,
    .datagram_end_i,
    .frame_valid_o  (front_valid),
    .frame_o        (front_frame)
  );

  dsfr_fifo #(.Width(FrameW), .Depth(QDepth)) u_mid_q (
    .clk_i,
    .rst_ni,
    .push_i  (front_valid),
    .data_i  (front_frame),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign back_frame = frame_t'(mid_data);

  dsfr_back u_back (
    .clk_i,
    .rst_ni,
    .frame_valid_i (!mid_empty),
    .frame_i       (back_frame),
    .frame_pop_o   (mid_pop),
    .res_ready_i   (!out_full),
    .res_push_o    (res_push),
    .res_o         (back_res)
  );

  dsfr_fifo #(.Width(ResultW), .Depth(QDepth)) u_out_q (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign out_res         = result_t'(out_data);
  assign event_res_o     = out_res.event_res;
  assign command_word_o  = out_res.command_word;
  assign deck_flags_o    = out_res.deck_flags;
  assign flags_updated_o = out_res.flags_updated;
  assign nack_reason_o   = out_res.nack_reason;

endmodule

`default_nettype wire
